@@ hw/rtl/mctw_pkg.sv @@
// Shared types, codes and reset values for the multi-channel task watchdog.
package mctw_pkg;

  // Default sizes of the slot table.
  localparam int SLOTS_DEFAULT       = 16;
  localparam int CLIENT_BITS_DEFAULT = 16;

  // Fixed field widths of the request, response and configuration channels.
  localparam int CMD_BITS    = 2;
  localparam int ID_BITS     = 16;
  localparam int STATUS_BITS = 2;
  localparam int SLOT_BITS   = 4;
  localparam int CFG_BITS    = 16;
  localparam int REG_BITS    = 1;
  localparam int TIME_BITS   = 32;

  // Request command codes.
  localparam logic [CMD_BITS-1:0] CMD_TICK       = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_REGISTER   = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_UNREGISTER = 2'd2;
  localparam logic [CMD_BITS-1:0] CMD_PET        = 2'd3;

  // Response status codes.
  localparam logic [STATUS_BITS-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_HANG = 2'd2;

  // Configuration register indexes.
  localparam logic [REG_BITS-1:0] REG_TIMEOUT  = 1'b0;
  localparam logic [REG_BITS-1:0] REG_INTERVAL = 1'b1;

  // Configuration reset values.
  localparam logic [CFG_BITS-1:0] TIMEOUT_RESET  = 16'd30;
  localparam logic [CFG_BITS-1:0] INTERVAL_RESET = 16'd5;

  // Operation carried by the token that walks the cell chain.
  typedef enum logic [1:0] {
    OP_SCAN,
    OP_REGISTER,
    OP_UNREGISTER,
    OP_PET
  } op_t;

  // Control part of the token handed from cell to cell.
  typedef struct packed {
    logic active;
    op_t  op;
    logic hit;
  } tok_ctrl_t;

  // One response as it leaves the block.
  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [SLOT_BITS-1:0]   slot;
    logic                   found;
    logic [ID_BITS-1:0]     hung_client;
  } rsp_t;

endpackage

@@ hw/rtl/mctw_ifs.sv @@
// Request, response and configuration channel interfaces of the watchdog.
interface mctw_req_if import mctw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_BITS-1:0] cmd;
  logic [ID_BITS-1:0]  client_id;

  modport source (output valid, cmd, client_id, input ready);
  modport sink   (input valid, cmd, client_id, output ready);
endinterface

interface mctw_rsp_if import mctw_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [STATUS_BITS-1:0] status;
  logic [SLOT_BITS-1:0]   slot;
  logic                   found;
  logic [ID_BITS-1:0]     hung_client;

  modport source (output valid, status, slot, found, hung_client, input ready);
  modport sink   (input valid, status, slot, found, hung_client, output ready);
endinterface

interface mctw_cfg_if import mctw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [REG_BITS-1:0] reg_index;
  logic [CFG_BITS-1:0] data;

  modport source (output valid, reg_index, data, input ready);
  modport sink   (input valid, reg_index, data, output ready);
endinterface

@@ hw/rtl/multi_channel_task_watchdog.sv @@
// Multi-channel task watchdog: a chain of slot cells behind a small command sequencer.
//
// Each of SLOTS slots holds a client id and the time of its last pet. Commands are
// tick (advance the seconds counter), register, unregister and pet; each request
// gives exactly one response. Register, unregister, pet and every tick that falls due
// for a scan send a token down the chain of slot cells, one cell per cycle, so that the
// lowest qualifying slot wins; such a request is not followed by the next acceptance
// until the token has left the last cell, so the chain length sets its time.
// A tick that does not scan, and any request once a hang is latched, skips the chain.
// A finished response waits in the output register while the next request is
// taken. Once a scan finds a slot idle longer than timeout_s, the block reports
// status 2 with that slot and its client on every response until reset.
// Configuration writes are taken at any time; registers are 0 timeout_s and
// 1 check_interval.
module multi_channel_task_watchdog import mctw_pkg::*; #(
  parameter int SLOTS       = SLOTS_DEFAULT,
  parameter int CLIENT_BITS = CLIENT_BITS_DEFAULT
) (
  input logic           clk,
  input logic           rst,
  mctw_req_if.sink      req,
  mctw_rsp_if.source    rsp,
  mctw_cfg_if.sink      cfg
);

  localparam int SB = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  state_t                 state;
  tok_ctrl_t              launch;
  logic [CLIENT_BITS-1:0] id;
  logic [TIME_BITS-1:0]   now_seconds;
  logic [CFG_BITS-1:0]    ticks_to_check;
  logic [CFG_BITS-1:0]    timeout_s;
  logic [CFG_BITS-1:0]    check_interval;
  logic                   hang_latched;
  logic [SB-1:0]          hang_slot;
  logic [CLIENT_BITS-1:0] hang_client;
  rsp_t                   pending;
  rsp_t                   out_rsp;
  logic                   out_valid;

  tok_ctrl_t              chain_ctrl   [SLOTS+1];
  logic [SB-1:0]          chain_slot   [SLOTS+1];
  logic [CLIENT_BITS-1:0] chain_client [SLOTS+1];
  logic [SLOTS:0]         chain_active;

  logic [CFG_BITS:0]      tick_sum;
  logic                   scan_due;
  tok_ctrl_t              end_ctrl;
  rsp_t                   end_rsp;
  rsp_t                   hang_rsp;
  op_t                    req_op;

  // Head of the chain is the launch register.
  assign chain_ctrl[0]   = launch;
  assign chain_slot[0]   = '0;
  assign chain_client[0] = '0;

  // Row of slot cells.
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    mctw_cell #(
      .IDX         (i),
      .SB          (SB),
      .CLIENT_BITS (CLIENT_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .id          (id),
      .now_seconds (now_seconds),
      .timeout_s   (timeout_s),
      .ctrl_in     (chain_ctrl[i]),
      .slot_in     (chain_slot[i]),
      .client_in   (chain_client[i]),
      .ctrl_out    (chain_ctrl[i+1]),
      .slot_out    (chain_slot[i+1]),
      .client_out  (chain_client[i+1])
    );
  end

  for (genvar i = 0; i <= SLOTS; i++) begin : g_active
    assign chain_active[i] = chain_ctrl[i].active;
  end

  // Scan is due when this tick completes the interval; zero acts as one.
  assign tick_sum = {1'b0, ticks_to_check} + {{CFG_BITS{1'b0}}, 1'b1};
  assign scan_due = tick_sum >= {1'b0, check_interval};

  // Map the request command onto the chain operation.
  always_comb begin
    unique case (req.cmd)
      CMD_REGISTER:   req_op = OP_REGISTER;
      CMD_UNREGISTER: req_op = OP_UNREGISTER;
      CMD_PET:        req_op = OP_PET;
      default:        req_op = OP_SCAN;
    endcase
  end

  // Response while the hang flag holds.
  always_comb begin
    hang_rsp             = '0;
    hang_rsp.status      = ST_HANG;
    hang_rsp.slot        = SLOT_BITS'(hang_slot);
    hang_rsp.hung_client = ID_BITS'(hang_client);
  end

  // Response formed from the token at the end of the chain.
  assign end_ctrl = chain_ctrl[SLOTS];

  always_comb begin
    end_rsp = '0;
    unique case (end_ctrl.op)
      OP_REGISTER: begin
        end_rsp.status = end_ctrl.hit ? ST_OK : ST_FULL;
        end_rsp.slot   = end_ctrl.hit ? SLOT_BITS'(chain_slot[SLOTS]) : '0;
      end
      OP_UNREGISTER, OP_PET: begin
        end_rsp.found = end_ctrl.hit;
      end
      OP_SCAN: begin
        if (end_ctrl.hit) begin
          end_rsp.status      = ST_HANG;
          end_rsp.slot        = SLOT_BITS'(chain_slot[SLOTS]);
          end_rsp.hung_client = ID_BITS'(chain_client[SLOTS]);
        end
      end
      default: end_rsp = '0;
    endcase
  end

  assign req.ready       = (state == S_IDLE);
  assign cfg.ready       = 1'b1;
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_rsp.status;
  assign rsp.slot        = out_rsp.slot;
  assign rsp.found       = out_rsp.found;
  assign rsp.hung_client = out_rsp.hung_client;

  // Command sequencer, configuration and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      launch         <= '0;
      now_seconds    <= '0;
      ticks_to_check <= '0;
      timeout_s      <= TIMEOUT_RESET;
      check_interval <= INTERVAL_RESET;
      hang_latched   <= 1'b0;
      hang_slot      <= '0;
      hang_client    <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.reg_index)
          REG_TIMEOUT:  timeout_s      <= cfg.data;
          REG_INTERVAL: check_interval <= cfg.data;
          default:      timeout_s      <= timeout_s;
        endcase
      end

      // The output register fills from the pending response and empties when taken.
      if (state == S_DONE && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            id <= CLIENT_BITS'(req.client_id);
            if (hang_latched) begin
              pending <= hang_rsp;
              state   <= S_DONE;
            end else if (req.cmd == CMD_TICK) begin
              now_seconds <= now_seconds + 1'b1;
              if (scan_due) begin
                ticks_to_check <= '0;
                launch         <= '{active: 1'b1, op: OP_SCAN, hit: 1'b0};
                state          <= S_RUN;
              end else begin
                ticks_to_check <= tick_sum[CFG_BITS-1:0];
                pending        <= '0;
                state          <= S_DONE;
              end
            end else begin
              launch <= '{active: 1'b1, op: req_op, hit: 1'b0};
              state  <= S_RUN;
            end
          end
        end
        S_RUN: begin
          // The token has entered the first cell, so the launch register empties.
          launch.active <= 1'b0;
          if (end_ctrl.active) begin
            pending <= end_rsp;
            if (end_ctrl.op == OP_SCAN && end_ctrl.hit) begin
              hang_latched <= 1'b1;
              hang_slot    <= chain_slot[SLOTS];
              hang_client  <= chain_client[SLOTS];
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || rsp.ready) begin
            out_rsp <= pending;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // Only one token walks the chain at a time.
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(chain_active))
    else $error("more than one token in the slot chain");

  // The hang flag holds until reset.
  a_hang_sticky: assert property (@(posedge clk) disable iff (rst)
    hang_latched |=> hang_latched)
    else $error("hang flag cleared without reset");

  // A hang response is only given once the flag is set.
  a_hang_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_rsp.status == ST_HANG) |-> hang_latched)
    else $error("hang reported without latched hang");

  // The chain is busy only while the sequencer waits on it.
  a_chain_run: assert property (@(posedge clk) disable iff (rst)
    (chain_active != '0) |-> (state == S_RUN))
    else $error("token in chain outside of run state");
`endif

endmodule

@@ hw/rtl/mctw_cell.sv @@
// One slot of the watchdog table, acting on the token as it passes by.
module mctw_cell import mctw_pkg::*; #(
  parameter int IDX         = 0,
  parameter int SB          = 4,
  parameter int CLIENT_BITS = CLIENT_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [CLIENT_BITS-1:0] id,
  input  logic [TIME_BITS-1:0]   now_seconds,
  input  logic [CFG_BITS-1:0]    timeout_s,
  input  tok_ctrl_t              ctrl_in,
  input  logic [SB-1:0]          slot_in,
  input  logic [CLIENT_BITS-1:0] client_in,
  output tok_ctrl_t              ctrl_out,
  output logic [SB-1:0]          slot_out,
  output logic [CLIENT_BITS-1:0] client_out
);

  logic                   valid;
  logic [CLIENT_BITS-1:0] client;
  logic [TIME_BITS-1:0]   last_pet;

  logic [TIME_BITS-1:0]   elapsed;
  logic                   overdue;
  logic                   match;
  logic                   take;
  tok_ctrl_t              ctrl_next;
  logic [SB-1:0]          slot_next;
  logic [CLIENT_BITS-1:0] client_next;

  // Elapsed time wraps with the seconds counter.
  assign elapsed = now_seconds - last_pet;
  assign overdue = elapsed > {{(TIME_BITS-CFG_BITS){1'b0}}, timeout_s};
  assign match   = valid && (client == id);

  // The first cell that qualifies claims the token; later cells pass it on.
  always_comb begin
    take        = 1'b0;
    ctrl_next   = ctrl_in;
    slot_next   = slot_in;
    client_next = client_in;
    if (ctrl_in.active && !ctrl_in.hit) begin
      unique case (ctrl_in.op)
        OP_SCAN:       take = valid && overdue;
        OP_REGISTER:   take = !valid;
        OP_UNREGISTER: take = match;
        OP_PET:        take = match;
        default:       take = 1'b0;
      endcase
    end
    if (take) begin
      ctrl_next.hit = 1'b1;
      slot_next     = SB'(IDX);
      client_next   = client;
    end
  end

  // Token stage toward the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out <= '0;
    end else begin
      ctrl_out <= ctrl_next;
    end
  end

  always_ff @(posedge clk) begin
    slot_out   <= slot_next;
    client_out <= client_next;
  end

  // Slot occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take && ctrl_in.op == OP_REGISTER) begin
      valid <= 1'b1;
    end else if (take && ctrl_in.op == OP_UNREGISTER) begin
      valid <= 1'b0;
    end
  end

  // Slot contents, written on register and stamped again on pet.
  always_ff @(posedge clk) begin
    if (take && ctrl_in.op == OP_REGISTER) begin
      client   <= id;
      last_pet <= now_seconds;
    end else if (take && ctrl_in.op == OP_PET) begin
      last_pet <= now_seconds;
    end
  end

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the multi-channel task watchdog with a built-in slot table model.
module tb;
  import mctw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_SLOTS = SLOTS_DEFAULT;
  localparam int POOL_SIZE   = 24;
  localparam int LONG_STALL  = 300;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [CMD_BITS-1:0] cmd;
    logic [ID_BITS-1:0]  client_id;
  } watchdog_cmd_t;

  logic clk = 1'b0;
  logic rst;

  mctw_req_if req_ch ();
  mctw_rsp_if rsp_ch ();
  mctw_cfg_if cfg_ch ();

  multi_channel_task_watchdog uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // Stimulus and response bookkeeping.
  watchdog_cmd_t command_q[$];
  rsp_t          due_q[$];
  watchdog_cmd_t next_cmd;
  rsp_t          want;
  logic          req_taken;
  int            mismatches  = 0;
  int            cycle_count = 0;
  int            send_gap_pct;
  int            recv_gap_pct;
  bit            long_stall_req  = 1'b0;
  bit            long_stall_done = 1'b0;
  int            stall_left      = 0;
  logic [ID_BITS-1:0] id_pool[POOL_SIZE];

  // Model state: slot table, seconds counter, scan counter and hang latch.
  logic                 table_valid[TABLE_SLOTS];
  logic [ID_BITS-1:0]   table_client[TABLE_SLOTS];
  logic [TIME_BITS-1:0] table_pet[TABLE_SLOTS];
  logic [TIME_BITS-1:0] clock_now;
  logic [CFG_BITS-1:0]  ticks_since_scan;
  logic                 hang_seen;
  logic [SLOT_BITS-1:0] hang_at;
  logic [CFG_BITS-1:0]  timeout_cfg;
  logic [CFG_BITS-1:0]  interval_cfg;

  // Clock with a 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Applies one command to the model table and returns the response it produces.
  function automatic rsp_t watchdog_response(input logic [CMD_BITS-1:0] cmd,
                                             input logic [ID_BITS-1:0]  id);
    rsp_t                 r;
    int                   pick;
    int                   i;
    logic [TIME_BITS-1:0] idle_for;
    logic [CFG_BITS:0]    next_count;
    r = '0;
    pick = -1;
    if (!hang_seen) begin
      case (cmd)
        CMD_TICK: begin
          clock_now = clock_now + 1'b1;
          next_count = {1'b0, ticks_since_scan} + 1'b1;
          // A zero interval compares as always due, so every tick scans.
          if (next_count >= {1'b0, interval_cfg}) begin
            ticks_since_scan = '0;
            for (i = 0; i < TABLE_SLOTS; i++) begin
              idle_for = clock_now - table_pet[i];
              if (pick < 0 && table_valid[i] && idle_for > timeout_cfg) pick = i;
            end
            if (pick >= 0) begin
              hang_seen = 1'b1;
              hang_at = SLOT_BITS'(pick);
            end
          end else begin
            ticks_since_scan = next_count[CFG_BITS-1:0];
          end
        end
        CMD_REGISTER: begin
          r.status = ST_FULL;
          for (i = 0; i < TABLE_SLOTS; i++)
            if (pick < 0 && !table_valid[i]) pick = i;
          if (pick >= 0) begin
            table_valid[pick] = 1'b1;
            table_client[pick] = id;
            table_pet[pick] = clock_now;
            r.status = ST_OK;
            r.slot = SLOT_BITS'(pick);
          end
        end
        default: begin
          // Unregister and pet touch only the lowest matching slot.
          for (i = 0; i < TABLE_SLOTS; i++)
            if (pick < 0 && table_valid[i] && table_client[i] == id) pick = i;
          if (pick >= 0) begin
            r.found = 1'b1;
            if (cmd == CMD_UNREGISTER) table_valid[pick] = 1'b0;
            else table_pet[pick] = clock_now;
          end
        end
      endcase
    end
    // Once latched, every response reports the hung slot, including the latching tick.
    if (hang_seen) begin
      r.status = ST_HANG;
      r.slot = hang_at;
      r.found = 1'b0;
      r.hung_client = table_client[hang_at];
    end
    return r;
  endfunction

  // Request driver: presents queued commands with random gaps.
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.cmd <= CMD_TICK;
      req_ch.client_id <= '0;
    end else if (!req_ch.valid || req_taken) begin
      if (command_q.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        next_cmd = command_q.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.cmd <= next_cmd.cmd;
        req_ch.client_id <= next_cmd.client_id;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Response acceptor: random stalls plus one long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (long_stall_req && !long_stall_done) begin
      rsp_ch.ready <= 1'b0;
      stall_left <= LONG_STALL;
      long_stall_done <= 1'b1;
    end else begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_gap_pct);
    end
  end

  // Monitor: checks each response against the oldest prediction, then predicts new requests.
  always @(posedge clk) begin
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_ch.valid && req_ch.ready;
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (due_q.size() == 0) begin
          $error("response with no request waiting: status %0d slot %0d",
                 rsp_ch.status, rsp_ch.slot);
          mismatches++;
        end else begin
          want = due_q.pop_front();
          if (rsp_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
            mismatches++;
          end
          if (rsp_ch.slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, rsp_ch.slot);
            mismatches++;
          end
          if (rsp_ch.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, rsp_ch.found);
            mismatches++;
          end
          if (rsp_ch.hung_client !== want.hung_client) begin
            $error("hung_client: expected 0x%04h, got 0x%04h",
                   want.hung_client, rsp_ch.hung_client);
            mismatches++;
          end
        end
      end
      if (req_ch.valid && req_ch.ready)
        due_q.push_back(watchdog_response(req_ch.cmd, req_ch.client_id));
    end
  end

  task automatic queue_cmd(input logic [CMD_BITS-1:0] cmd, input logic [ID_BITS-1:0] id);
    command_q.push_back('{cmd: cmd, client_id: id});
  endtask

  // Random mix; most ids come from a small pool so that pets and unregisters hit.
  task automatic queue_random(input int count);
    int                  k;
    int                  roll;
    logic [CMD_BITS-1:0] cmd;
    logic [ID_BITS-1:0]  id;
    for (k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 25) cmd = CMD_TICK;
      else if (roll < 50) cmd = CMD_REGISTER;
      else if (roll < 75) cmd = CMD_UNREGISTER;
      else cmd = CMD_PET;
      if ($urandom_range(0, 99) < 85) id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
      else id = ID_BITS'($urandom);
      queue_cmd(cmd, id);
    end
  endtask

  // Holds the sender back until every request has been answered.
  task automatic wait_drained();
    do @(posedge clk);
    while (command_q.size() != 0 || req_ch.valid || due_q.size() != 0);
  endtask

  // Writes one configuration register and mirrors it into the model.
  task automatic write_reg(input logic [REG_BITS-1:0] idx, input logic [CFG_BITS-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk);
    while (!(cfg_ch.valid && cfg_ch.ready));
    if (idx == REG_TIMEOUT) timeout_cfg = value;
    else interval_cfg = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb failed");
    $finish;
  end

  initial begin
    int k;
    rst = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_index = REG_TIMEOUT;
    cfg_ch.data = '0;
    send_gap_pct = 33;
    recv_gap_pct = 48;

    // Model reset state.
    for (k = 0; k < TABLE_SLOTS; k++) begin
      table_valid[k] = 1'b0;
      table_client[k] = '0;
      table_pet[k] = '0;
    end
    clock_now = '0;
    ticks_since_scan = '0;
    hang_seen = 1'b0;
    hang_at = '0;
    timeout_cfg = TIMEOUT_RESET;
    interval_cfg = INTERVAL_RESET;

    id_pool[0] = '0;
    id_pool[1] = '1;
    for (k = 2; k < POOL_SIZE; k++) id_pool[k] = ID_BITS'($urandom);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed commands under the reset configuration: ticks without a scan,
    // extreme ids, a duplicate id, misses, then fill the table and overflow it.
    queue_cmd(CMD_TICK, '0);
    queue_cmd(CMD_TICK, '1);
    queue_cmd(CMD_REGISTER, '0);
    queue_cmd(CMD_REGISTER, '1);
    queue_cmd(CMD_REGISTER, '1);
    queue_cmd(CMD_PET, '1);
    queue_cmd(CMD_UNREGISTER, '1);
    queue_cmd(CMD_PET, '1);
    queue_cmd(CMD_UNREGISTER, 16'h1234);
    queue_cmd(CMD_PET, 16'h5555);
    for (k = 2; k < 16; k++) queue_cmd(CMD_REGISTER, id_pool[k]);
    queue_cmd(CMD_REGISTER, id_pool[16]);
    wait_drained();

    // Zero interval scans on every tick; an idle time equal to the timeout is no hang.
    write_reg(REG_TIMEOUT, 16'd2);
    write_reg(REG_INTERVAL, 16'd0);
    queue_cmd(CMD_TICK, '0);
    queue_cmd(CMD_TICK, '0);
    wait_drained();

    // Scan every tick with the longest timeout; the sender pauses halfway.
    write_reg(REG_TIMEOUT, 16'hFFFF);
    write_reg(REG_INTERVAL, 16'd1);
    queue_random(65);
    wait_drained();
    queue_random(65);
    wait_drained();

    // Longest interval, so ticks pile up without a scan.
    send_gap_pct = 48;
    recv_gap_pct = 33;
    write_reg(REG_TIMEOUT, CFG_BITS'($urandom_range(1000, 65535)));
    write_reg(REG_INTERVAL, 16'hFFFF);
    queue_random(130);
    wait_drained();

    // No gaps at all, with one long receiver hold-off to back the block up.
    send_gap_pct = 0;
    recv_gap_pct = 0;
    write_reg(REG_TIMEOUT, CFG_BITS'($urandom_range(1000, 65535)));
    write_reg(REG_INTERVAL, CFG_BITS'($urandom_range(2, 40)));
    queue_random(130);
    long_stall_req = 1'b1;
    wait_drained();

    // Zero timeout: the next tick latches a hang, after which the block is frozen.
    write_reg(REG_TIMEOUT, 16'd0);
    write_reg(REG_INTERVAL, 16'd0);
    queue_cmd(CMD_REGISTER, id_pool[0]);
    queue_cmd(CMD_TICK, '0);
    queue_random(15);
    wait_drained();

    repeat (40) @(posedge clk);
    if (mismatches == 0 && due_q.size() == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
